// File: sv/unit_propagation_rounds_core_macros.svh
// Assertion macros used by the RTL file unit_propagation_rounds_core.sv.
`ifndef UNIT_PROPAGATION_ROUNDS_CORE_MACROS_SVH
`define UNIT_PROPAGATION_ROUNDS_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define UPR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define UPR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/upr_pkg.sv
package upr_pkg;

    localparam int MAX_LITERALS = 4096;
    localparam int MAX_CLAUSES  = 1024;
    localparam int MAX_VARS     = 256;

    localparam int LIT_W  = 64;
    localparam int CL_W   = 10;
    localparam int LIT_AW = $clog2(MAX_LITERALS);
    localparam int LIT_CW = LIT_AW + 1;
    localparam int CL_AW  = $clog2(MAX_CLAUSES);
    localparam int CL_CW  = CL_AW + 1;
    localparam int VAR_AW = $clog2(MAX_VARS);
    localparam int VAR_CW = VAR_AW + 1;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_FETCH = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    localparam logic [1:0] LV_UNASSIGNED = 2'd0;
    localparam logic [1:0] LV_FALSE      = 2'd1;
    localparam logic [1:0] LV_TRUE       = 2'd2;

    typedef enum logic [1:0] {
        PH_LOAD = 2'd0,
        PH_RUN  = 2'd1,
        PH_DONE = 2'd2
    } t_phase;

    typedef struct packed {
        logic [LIT_W-1:0] id;
        logic             val;
    } t_var_entry;

    typedef struct packed {
        logic [LIT_W-1:0] lit;
        logic [CL_W-1:0]  clause;
    } t_round_entry;

endpackage

// File: sv/upr_ram.sv
module upr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/unit_propagation_rounds_core.sv
// Channel | Handshake                 | Payload
// input   | i_in_valid / o_in_stall   | i_action, i_literal, i_clause_end
// output  | o_out_valid / i_out_stall | o_prop_valid, o_prop_literal, o_prop_clause,
//         |                           | o_round_last, o_lit_value, o_store_full
// The time a query takes grows with the number of assigned variables, set by the
// linear search of the variable memory through its single read port.
// A fetch that starts a round walks every live clause, searching the variable memory
// for each literal scanned, then applies each propagation with a further search.
// One transaction is worked on at a time; the result sits in an output register, so a
// stalled output only holds the block once the next result is ready.
// Reset is synchronous and clears counters and phase; the memories need no clearing.
`include "unit_propagation_rounds_core_macros.svh"

module unit_propagation_rounds_core
    import upr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [1:0]       i_action,
    input  logic [LIT_W-1:0] i_literal,
    input  logic             i_clause_end,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_prop_valid,
    output logic [LIT_W-1:0] o_prop_literal,
    output logic [CL_W-1:0]  o_prop_clause,
    output logic             o_round_last,
    output logic [1:0]       o_lit_value,
    output logic             o_store_full
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_S_RD, ST_S_CMP, ST_Q_DONE,
        ST_R_CL, ST_R_CL2, ST_R_END, ST_R_START, ST_R_LIT, ST_R_LIT2, ST_R_LITV,
        ST_R_CLEND, ST_R_APPLY, ST_R_AP2, ST_R_AP3,
        ST_F_RD, ST_F_DATA, ST_EMIT
    } t_state;

    function automatic logic [LIT_W-1:0] var_of(input logic [LIT_W-1:0] lit);
        return lit[LIT_W-1] ? ~lit : lit;
    endfunction

    t_state r_state, n_state, r_ret, n_ret;
    t_phase r_phase, n_phase;
    logic              r_full, n_full;
    logic [LIT_CW-1:0] r_n_lits, n_n_lits, r_open_start, n_open_start;
    logic [CL_CW-1:0]  r_n_clauses, n_n_clauses, r_n_live, n_n_live;
    logic [CL_CW-1:0]  r_n_round, n_n_round, r_round_pos, n_round_pos;
    logic [CL_CW-1:0]  r_k, n_k, r_keep, n_keep;
    logic [VAR_CW-1:0] r_n_vars, n_n_vars, r_si, n_si;
    logic              r_out_valid, n_out_valid;

    logic [CL_W-1:0]   r_c, n_c;
    logic [LIT_CW-1:0] r_j, n_j, r_end, n_end;
    logic [LIT_W-1:0]  r_lit, n_lit, r_unit, n_unit, r_target, n_target;
    logic              r_have_unit, n_have_unit, r_retain, n_retain;
    logic              r_found, n_found, r_fval, n_fval;
    logic [VAR_AW-1:0] r_fidx, n_fidx;

    logic              r_res_pv, n_res_pv, r_res_rl, n_res_rl;
    logic [LIT_W-1:0]  r_res_lit, n_res_lit;
    logic [CL_W-1:0]   r_res_cl, n_res_cl;
    logic [1:0]        r_res_lv, n_res_lv;

    logic              r_o_pv, r_o_rl, r_o_full;
    logic [LIT_W-1:0]  r_o_lit;
    logic [CL_W-1:0]   r_o_cl;
    logic [1:0]        r_o_lv;
    logic              load_out;

    // Memory ports.
    logic              lit_we;
    logic [LIT_AW-1:0] lit_waddr, lit_raddr;
    logic [LIT_W-1:0]  lit_wdata, lit_rdata;
    logic              cend_we;
    logic [CL_AW-1:0]  cend_waddr, cend_raddr;
    logic [LIT_CW-1:0] cend_wdata, cend_rdata;
    logic              live_we;
    logic [CL_AW-1:0]  live_waddr, live_raddr;
    logic [CL_W-1:0]   live_wdata, live_rdata;
    logic              var_we;
    logic [VAR_AW-1:0] var_waddr, var_raddr;
    t_var_entry        var_wdata, var_rdata;
    logic              rb_we;
    logic [CL_AW-1:0]  rb_waddr, rb_raddr;
    t_round_entry      rb_wdata, rb_rdata;

    logic [LIT_CW-1:0] lits_after;
    logic [1:0]        cur_lv;
    t_phase            fetch_phase;

    assign cur_lv = !r_found ? LV_UNASSIGNED
                  : ((r_fval ^ r_lit[LIT_W-1]) ? LV_TRUE : LV_FALSE);
    assign lits_after = (r_n_lits < LIT_CW'(MAX_LITERALS)) ? r_n_lits + 1'b1 : r_n_lits;
    assign fetch_phase = (r_phase == PH_LOAD) ? PH_RUN : r_phase;

    always_comb begin
        n_state = r_state; n_ret = r_ret; n_phase = r_phase; n_full = r_full;
        n_n_lits = r_n_lits; n_open_start = r_open_start;
        n_n_clauses = r_n_clauses; n_n_live = r_n_live; n_n_round = r_n_round;
        n_round_pos = r_round_pos; n_k = r_k; n_keep = r_keep;
        n_n_vars = r_n_vars; n_si = r_si;
        n_c = r_c; n_j = r_j; n_end = r_end; n_lit = r_lit; n_unit = r_unit;
        n_target = r_target; n_have_unit = r_have_unit; n_retain = r_retain;
        n_found = r_found; n_fval = r_fval; n_fidx = r_fidx;
        n_res_pv = r_res_pv; n_res_rl = r_res_rl; n_res_lit = r_res_lit;
        n_res_cl = r_res_cl; n_res_lv = r_res_lv;
        load_out = 1'b0;

        lit_we = 1'b0; lit_waddr = r_n_lits[LIT_AW-1:0]; lit_wdata = i_literal;
        lit_raddr = r_j[LIT_AW-1:0];
        cend_we = 1'b0; cend_waddr = r_n_clauses[CL_AW-1:0]; cend_wdata = lits_after;
        cend_raddr = r_c;
        live_we = 1'b0; live_waddr = r_n_live[CL_AW-1:0];
        live_wdata = r_n_clauses[CL_W-1:0];
        live_raddr = r_k[CL_AW-1:0];
        var_we = 1'b0; var_waddr = r_fidx;
        var_wdata = '{id: var_of(r_lit), val: !r_lit[LIT_W-1]};
        var_raddr = r_si[VAR_AW-1:0];
        rb_we = 1'b0; rb_waddr = r_n_round[CL_AW-1:0];
        rb_wdata = '{lit: r_unit, clause: r_c};
        rb_raddr = r_k[CL_AW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (t_action'(i_action))
                        ACT_LOAD: begin
                            if (r_phase == PH_LOAD) begin
                                if (r_n_lits < LIT_CW'(MAX_LITERALS)) begin
                                    lit_we = 1'b1;
                                end else begin
                                    n_full = 1'b1;
                                end
                                n_n_lits = lits_after;
                                n_open_start = lits_after;
                                if (i_clause_end) begin
                                    if (r_n_clauses < CL_CW'(MAX_CLAUSES)) begin
                                        cend_we = 1'b1;
                                        live_we = 1'b1;
                                        n_n_live = r_n_live + 1'b1;
                                        n_n_clauses = r_n_clauses + 1'b1;
                                    end else begin
                                        n_full = 1'b1;
                                        n_n_lits = r_open_start;
                                        n_open_start = r_open_start;
                                    end
                                end else begin
                                    n_open_start = r_open_start;
                                end
                            end
                        end
                        ACT_FETCH: begin
                            n_phase = fetch_phase;
                            if (fetch_phase == PH_RUN && r_round_pos >= r_n_round) begin
                                n_k = '0; n_keep = '0; n_n_round = '0; n_round_pos = '0;
                                n_state = ST_R_CL;
                            end else begin
                                n_state = ST_F_RD;
                            end
                        end
                        ACT_QUERY: begin
                            n_lit = i_literal;
                            n_target = var_of(i_literal);
                            n_si = '0;
                            n_ret = ST_Q_DONE;
                            n_state = ST_S_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // Linear search of the variable memory for r_target.
            ST_S_RD: begin
                if (r_si >= r_n_vars) begin
                    n_found = 1'b0;
                    n_state = r_ret;
                end else begin
                    n_state = ST_S_CMP;
                end
            end
            ST_S_CMP: begin
                if (var_rdata.id == r_target) begin
                    n_found = 1'b1;
                    n_fval = var_rdata.val;
                    n_fidx = r_si[VAR_AW-1:0];
                    n_state = r_ret;
                end else begin
                    n_si = r_si + 1'b1;
                    n_state = ST_S_RD;
                end
            end
            ST_Q_DONE: begin
                n_res_pv = 1'b0; n_res_lit = '0; n_res_cl = '0; n_res_rl = 1'b0;
                n_res_lv = cur_lv;
                n_state = ST_EMIT;
            end
            ST_R_CL: begin
                if (r_k >= r_n_live) begin
                    n_n_live = r_keep;
                    n_k = '0;
                    n_state = ST_R_APPLY;
                end else begin
                    n_state = ST_R_CL2;
                end
            end
            ST_R_CL2: begin
                n_c = live_rdata;
                n_have_unit = 1'b0;
                n_retain = 1'b0;
                if (CL_CW'(live_rdata) >= r_n_clauses) begin
                    n_k = r_k + 1'b1;
                    n_state = ST_R_CL;
                end else begin
                    cend_raddr = live_rdata;
                    n_state = ST_R_END;
                end
            end
            ST_R_END: begin
                n_end = cend_rdata;
                if (r_c != '0) begin
                    cend_raddr = r_c - 1'b1;
                    n_state = ST_R_START;
                end else begin
                    n_j = '0;
                    n_state = ST_R_LIT;
                end
            end
            ST_R_START: begin
                n_j = cend_rdata;
                n_state = ST_R_LIT;
            end
            ST_R_LIT: begin
                if (r_j >= r_end) begin
                    n_state = ST_R_CLEND;
                end else begin
                    n_state = ST_R_LIT2;
                end
            end
            ST_R_LIT2: begin
                n_lit = lit_rdata;
                n_target = var_of(lit_rdata);
                n_si = '0;
                n_ret = ST_R_LITV;
                n_state = ST_S_RD;
            end
            ST_R_LITV: begin
                if (cur_lv == LV_TRUE) begin
                    n_have_unit = 1'b0;
                    n_state = ST_R_CLEND;
                end else if (cur_lv == LV_UNASSIGNED && r_have_unit) begin
                    n_retain = 1'b1;
                    n_have_unit = 1'b0;
                    n_state = ST_R_CLEND;
                end else begin
                    if (cur_lv == LV_UNASSIGNED) begin
                        n_have_unit = 1'b1;
                        n_unit = r_lit;
                    end
                    n_j = r_j + 1'b1;
                    n_state = ST_R_LIT;
                end
            end
            ST_R_CLEND: begin
                if (r_have_unit && r_n_round < CL_CW'(MAX_CLAUSES)) begin
                    rb_we = 1'b1;
                    n_n_round = r_n_round + 1'b1;
                end
                if (r_retain) begin
                    live_we = 1'b1;
                    live_waddr = r_keep[CL_AW-1:0];
                    live_wdata = r_c;
                    n_keep = r_keep + 1'b1;
                end
                n_k = r_k + 1'b1;
                n_state = ST_R_CL;
            end
            // Assignments of the round, applied in clause order.
            ST_R_APPLY: begin
                if (r_k >= r_n_round) begin
                    if (r_n_round == '0) begin
                        n_phase = PH_DONE;
                    end
                    n_state = ST_F_RD;
                end else begin
                    n_state = ST_R_AP2;
                end
            end
            ST_R_AP2: begin
                n_lit = rb_rdata.lit;
                n_target = var_of(rb_rdata.lit);
                n_si = '0;
                n_ret = ST_R_AP3;
                n_state = ST_S_RD;
            end
            ST_R_AP3: begin
                if (r_found) begin
                    var_we = 1'b1;
                end else if (r_n_vars < VAR_CW'(MAX_VARS)) begin
                    var_we = 1'b1;
                    var_waddr = r_n_vars[VAR_AW-1:0];
                    n_n_vars = r_n_vars + 1'b1;
                end else begin
                    n_full = 1'b1;
                end
                n_k = r_k + 1'b1;
                n_state = ST_R_APPLY;
            end
            ST_F_RD: begin
                rb_raddr = r_round_pos[CL_AW-1:0];
                if (r_round_pos < r_n_round) begin
                    n_state = ST_F_DATA;
                end else begin
                    n_res_pv = 1'b0; n_res_lit = '0; n_res_cl = '0; n_res_rl = 1'b0;
                    n_res_lv = LV_UNASSIGNED;
                    n_state = ST_EMIT;
                end
            end
            ST_F_DATA: begin
                n_res_pv = 1'b1;
                n_res_lit = rb_rdata.lit;
                n_res_cl = rb_rdata.clause;
                n_res_rl = (r_round_pos + 1'b1 == r_n_round);
                n_res_lv = LV_UNASSIGNED;
                n_round_pos = r_round_pos + 1'b1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_out_valid = load_out ? 1'b1 : (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_ret <= ST_IDLE; r_phase <= PH_LOAD; r_full <= 1'b0;
            r_n_lits <= '0; r_open_start <= '0; r_n_clauses <= '0; r_n_live <= '0;
            r_n_round <= '0; r_round_pos <= '0; r_k <= '0; r_keep <= '0;
            r_n_vars <= '0; r_si <= '0; r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state; r_ret <= n_ret; r_phase <= n_phase; r_full <= n_full;
            r_n_lits <= n_n_lits; r_open_start <= n_open_start;
            r_n_clauses <= n_n_clauses; r_n_live <= n_n_live;
            r_n_round <= n_n_round; r_round_pos <= n_round_pos; r_k <= n_k;
            r_keep <= n_keep; r_n_vars <= n_n_vars; r_si <= n_si;
            r_out_valid <= n_out_valid;
        end
        r_c <= n_c; r_j <= n_j; r_end <= n_end; r_lit <= n_lit; r_unit <= n_unit;
        r_target <= n_target; r_have_unit <= n_have_unit; r_retain <= n_retain;
        r_found <= n_found; r_fval <= n_fval; r_fidx <= n_fidx;
        r_res_pv <= n_res_pv; r_res_rl <= n_res_rl; r_res_lit <= n_res_lit;
        r_res_cl <= n_res_cl; r_res_lv <= n_res_lv;
        if (load_out) begin
            r_o_pv <= r_res_pv; r_o_rl <= r_res_rl; r_o_lit <= r_res_lit;
            r_o_cl <= r_res_cl; r_o_lv <= r_res_lv; r_o_full <= r_full;
        end
    end

    upr_ram #(.WIDTH(LIT_W), .DEPTH(MAX_LITERALS)) u_lit_ram (
        .i_clk(i_clk), .i_we(lit_we), .i_waddr(lit_waddr), .i_wdata(lit_wdata),
        .i_raddr(lit_raddr), .o_rdata(lit_rdata)
    );

    upr_ram #(.WIDTH(LIT_CW), .DEPTH(MAX_CLAUSES)) u_cend_ram (
        .i_clk(i_clk), .i_we(cend_we), .i_waddr(cend_waddr), .i_wdata(cend_wdata),
        .i_raddr(cend_raddr), .o_rdata(cend_rdata)
    );

    upr_ram #(.WIDTH(CL_W), .DEPTH(MAX_CLAUSES)) u_live_ram (
        .i_clk(i_clk), .i_we(live_we), .i_waddr(live_waddr), .i_wdata(live_wdata),
        .i_raddr(live_raddr), .o_rdata(live_rdata)
    );

    upr_ram #(.WIDTH($bits(t_var_entry)), .DEPTH(MAX_VARS)) u_var_ram (
        .i_clk(i_clk), .i_we(var_we), .i_waddr(var_waddr), .i_wdata(var_wdata),
        .i_raddr(var_raddr), .o_rdata(var_rdata)
    );

    upr_ram #(.WIDTH($bits(t_round_entry)), .DEPTH(MAX_CLAUSES)) u_round_ram (
        .i_clk(i_clk), .i_we(rb_we), .i_waddr(rb_waddr), .i_wdata(rb_wdata),
        .i_raddr(rb_raddr), .o_rdata(rb_rdata)
    );

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_prop_valid   = r_o_pv;
    assign o_prop_literal = r_o_lit;
    assign o_prop_clause  = r_o_cl;
    assign o_round_last   = r_o_rl;
    assign o_lit_value    = r_o_lv;
    assign o_store_full   = r_o_full;

    // Compaction writes never overtake the read position of the live list.
    `UPR_ASSERT_IMP(a_keep_behind, i_clk, i_rst_n, r_state == ST_R_CL, r_keep <= r_k, "keep ahead")
    // Outside a transaction, the fetch position never passes the round size.
    `UPR_ASSERT_IMP(a_pos_bound, i_clk, i_rst_n, r_state == ST_IDLE, r_round_pos <= r_n_round, "overrun")
    // Once propagation has finished it stays finished.
    `UPR_ASSERT_NXT(a_done_sticky, i_clk, i_rst_n, r_phase == PH_DONE, r_phase == PH_DONE, "left done")
    // The store-full flag never clears once set.
    `UPR_ASSERT_NXT(a_full_sticky, i_clk, i_rst_n, r_full, r_full, "store full flag dropped")

endmodule
